[sv/lkvc_pkg.sv]
package lkvc_pkg;

   localparam int ENTRIES   = 16;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int RANK_W    = IDX_W;
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic              vld;
      logic [IDX_W-1:0]  idx;
      logic              entry_valid;
      logic [RANK_W-1:0] rank;
   } scan_beat_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_idx;
      logic [IDX_W-1:0] free_idx;
      logic [IDX_W-1:0] victim_idx;
   } scan_result_type;

endpackage

[sv/lkvc_kv_mem.sv]
module lkvc_kv_mem (
   input  logic                        clock,
   input  logic [lkvc_pkg::IDX_W-1:0]  rd_addr,
   input  logic [lkvc_pkg::IDX_W-1:0]  wr_addr,
   input  logic                        wr_key_en,
   input  logic                        wr_val_en,
   input  logic [lkvc_pkg::KEY_W-1:0]  wr_key,
   input  logic [lkvc_pkg::VAL_W-1:0]  wr_val,
   output logic [lkvc_pkg::KEY_W-1:0]  key_rd,
   output logic [lkvc_pkg::VAL_W-1:0]  val_rd
);

   logic [lkvc_pkg::KEY_W-1:0] key_mem [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0] val_mem [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::KEY_W-1:0] key_rd_ff;
   logic [lkvc_pkg::VAL_W-1:0] val_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   assign key_rd = key_rd_ff;
   assign val_rd = val_rd_ff;

endmodule

[sv/lkvc_scan_unit.sv]
module lkvc_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  lkvc_pkg::scan_beat_type       beat,
   input  logic [lkvc_pkg::KEY_W-1:0]    key_rd,
   input  logic [lkvc_pkg::KEY_W-1:0]    req_key,
   output lkvc_pkg::scan_result_type     result
);

   logic                          found_ff, found_in;
   logic                          free_found_ff, free_found_in;
   logic                          any_ff, any_in;
   logic [lkvc_pkg::IDX_W-1:0]    match_ff, match_in;
   logic [lkvc_pkg::IDX_W-1:0]    free_ff, free_in;
   logic [lkvc_pkg::IDX_W-1:0]    victim_ff, victim_in;
   logic [lkvc_pkg::RANK_W-1:0]   best_ff, best_in;
   logic                          key_eq;
   logic                          rank_gt;

   assign key_eq  = (key_rd == req_key);
   assign rank_gt = (beat.rank > best_ff);

   always_comb begin
      found_in      = found_ff;
      free_found_in = free_found_ff;
      any_in        = any_ff;
      match_in      = match_ff;
      free_in       = free_ff;
      victim_in     = victim_ff;
      best_in       = best_ff;
      if (start) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
         any_in        = 1'b0;
      end else if (beat.vld) begin
         if (beat.entry_valid) begin
            if (key_eq && !found_ff) begin
               found_in = 1'b1;
               match_in = beat.idx;
            end
            if (!any_ff || rank_gt) begin
               any_in    = 1'b1;
               best_in   = beat.rank;
               victim_in = beat.idx;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_in       = beat.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         any_ff        <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         any_ff        <= any_in;
      end
      match_ff  <= match_in;
      free_ff   <= free_in;
      victim_ff <= victim_in;
      best_ff   <= best_in;
   end

   assign result.found      = found_ff;
   assign result.match_idx  = match_ff;
   assign result.free_idx   = free_ff;
   assign result.victim_idx = victim_ff;

endmodule

[sv/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement, ENTRIES slots.
// One request beat at a time: after a beat is taken the block walks every slot through a
// single key comparator, one slot per cycle, then waits for the registered memory read and
// the last compare; it then chooses the slot, and then does the data memory access and
// recency update, before its response beat is offered. A read miss skips the memory access
// and recency update. req_tready stays low until that response beat is taken.
// Capacity (csr) is sampled per request; 0 acts as 1 and values above ENTRIES act as
// ENTRIES. Lowering it below the current fill drops nothing; a later write miss then evicts
// the least recent entry in place.
module lru_key_value_cache (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // key[31:0], value[63:32]
   input  logic         req_tuser,   // mode (0 read, 1 write)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // read_value[31:0], evicted_key[63:32]
   output logic [1:0]   rsp_tuser,   // hit[0], evicted[1]
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data  // capacity_in_use
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEARCH  = 5'b00010,
      ST_DECIDE  = 5'b00100,
      ST_FETCH   = 5'b01000,
      ST_RESPOND = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [lkvc_pkg::CAP_W-1:0]      cap_ff;
   logic [lkvc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [lkvc_pkg::CNT_W-1:0]      addr_ff, addr_in;
   logic [lkvc_pkg::CNT_W-1:0]      eff_cap;
   logic [lkvc_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [lkvc_pkg::RANK_W-1:0]     rank_ff [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::RANK_W-1:0]     rank_in [lkvc_pkg::ENTRIES];
   logic                            mode_ff;
   logic [lkvc_pkg::KEY_W-1:0]      key_ff;
   logic [lkvc_pkg::VAL_W-1:0]      value_ff;
   logic                            pvld_ff, pvld_in;
   logic [lkvc_pkg::IDX_W-1:0]      pidx_ff;
   logic [lkvc_pkg::IDX_W-1:0]      slot_ff, slot_sel;
   logic                            full_ff, full_now;
   logic                            hit_ff, ev_ff;
   logic [lkvc_pkg::VAL_W-1:0]      rd_ff;
   logic [lkvc_pkg::KEY_W-1:0]      evk_ff;
   logic [lkvc_pkg::IDX_W-1:0]      rd_addr;
   logic [lkvc_pkg::KEY_W-1:0]      key_rd;
   logic [lkvc_pkg::VAL_W-1:0]      val_rd;
   logic [lkvc_pkg::RANK_W-1:0]     old_rank;
   logic                            req_take, rsp_take, scan_start;
   lkvc_pkg::scan_beat_type         beat;
   lkvc_pkg::scan_result_type       scan;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESPOND);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign scan_start = req_take;
   assign rsp_tdata  = {evk_ff, rd_ff};
   assign rsp_tuser  = {ev_ff, hit_ff};

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkvc_pkg::CNT_W'(1);
      end else if (int'(cap_ff) > lkvc_pkg::ENTRIES) begin
         eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
      end else begin
         eff_cap = lkvc_pkg::CNT_W'(cap_ff);
      end
   end

   assign full_now = (count_ff >= eff_cap);

   always_comb begin
      if (scan.found) begin
         slot_sel = scan.match_idx;
      end else if (full_now) begin
         slot_sel = scan.victim_idx;
      end else begin
         slot_sel = scan.free_idx;
      end
   end

   always_comb begin
      case (state_ff)
         ST_SEARCH: rd_addr = addr_ff[lkvc_pkg::IDX_W-1:0];
         ST_DECIDE: rd_addr = slot_sel;
         default:   rd_addr = slot_ff;
      endcase
   end

   assign beat.vld         = pvld_ff;
   assign beat.idx         = pidx_ff;
   assign beat.entry_valid = valid_ff[pidx_ff];
   assign beat.rank        = rank_ff[pidx_ff];

   lkvc_scan_unit u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .beat    (beat),
      .key_rd  (key_rd),
      .req_key (key_ff),
      .result  (scan)
   );

   lkvc_kv_mem u_mem (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .wr_addr   (slot_ff),
      .wr_key_en ((state_ff == ST_FETCH) && (mode_ff == lkvc_pkg::MODE_WRITE) && !scan.found),
      .wr_val_en ((state_ff == ST_FETCH) && (mode_ff == lkvc_pkg::MODE_WRITE)),
      .wr_key    (key_ff),
      .wr_val    (value_ff),
      .key_rd    (key_rd),
      .val_rd    (val_rd)
   );

   assign old_rank = rank_ff[slot_ff];

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      pvld_in  = 1'b0;
      count_in = count_ff;
      valid_in = valid_ff;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (req_take) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (int'(addr_ff) < lkvc_pkg::ENTRIES) begin
               addr_in = addr_ff + lkvc_pkg::CNT_W'(1);
               pvld_in = 1'b1;
            end else if (!pvld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!scan.found && (mode_ff == lkvc_pkg::MODE_READ)) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESPOND;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
               if (lkvc_pkg::IDX_W'(i) == slot_ff) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (!valid_ff[slot_ff] || rank_ff[i] < old_rank)) begin
                  rank_in[i] = rank_ff[i] + lkvc_pkg::RANK_W'(1);
               end
            end
            if (!scan.found && !full_ff) begin
               valid_in[slot_ff] = 1'b1;
               count_in          = count_ff + lkvc_pkg::CNT_W'(1);
            end
         end
         ST_RESPOND: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
         count_ff <= '0;
         addr_ff  <= '0;
         valid_ff <= '0;
         pvld_ff  <= 1'b0;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         valid_ff <= valid_in;
         pvld_ff  <= pvld_in;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      pidx_ff <= addr_ff[lkvc_pkg::IDX_W-1:0];
      if (req_take) begin
         mode_ff  <= req_tuser;
         key_ff   <= req_tdata[31:0];
         value_ff <= req_tdata[63:32];
      end
      if (state_ff == ST_DECIDE) begin
         slot_ff <= slot_sel;
         full_ff <= full_now;
         hit_ff  <= scan.found;
         rd_ff   <= '0;
         ev_ff   <= 1'b0;
         evk_ff  <= '0;
      end
      if (state_ff == ST_FETCH) begin
         if (scan.found && (mode_ff == lkvc_pkg::MODE_READ)) begin
            rd_ff <= val_rd;
         end
         if (!scan.found && full_ff) begin
            ev_ff  <= 1'b1;
            evk_ff <= key_rd;
         end
      end
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= lkvc_pkg::ENTRIES)
      else $error("entry count above slot total");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count disagrees with valid bits");

   a_touch_most_recent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (rank_ff[slot_ff] == '0) && valid_ff[slot_ff])
      else $error("touched slot not most recent");

endmodule

[sim/lru_key_value_cache_test.sv]
module lru_key_value_cache_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 150;
   localparam int HOLD_AFTER  = 700;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic                       hit;
      logic [lkvc_pkg::VAL_W-1:0] read_value;
      logic                       evicted;
      logic [lkvc_pkg::KEY_W-1:0] evicted_key;
   } reply_type;

   typedef enum logic {STEP_ACCESS, STEP_CAPACITY} step_kind_type;

   typedef struct {
      step_kind_type              kind;
      logic                       mode;
      logic [lkvc_pkg::KEY_W-1:0] key;
      logic [lkvc_pkg::VAL_W-1:0] value;
      bit                         given;
      reply_type                  want;
   } step_type;

   localparam logic [31:0] KMIN = 32'h8000_0000;
   localparam logic [31:0] KMAX = 32'h7fff_ffff;
   localparam logic [31:0] ONES = 32'hffff_ffff;
   localparam reply_type   MISS = '0;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata   = '0;
   logic         req_tuser   = lkvc_pkg::MODE_READ;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_wr_en   = 1'b0;
   logic [4:0]   csr_wr_data = '0;

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [lkvc_pkg::KEY_W-1:0]  slot_key   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0]  slot_value [lkvc_pkg::ENTRIES];
   bit                          slot_used  [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::RANK_W-1:0] slot_age   [lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::CNT_W-1:0]  slots_filled = '0;
   logic [lkvc_pkg::CAP_W-1:0]  capacity_reg = lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);

   reply_type   replies_due [$];
   int          failures    = 0;
   int          replies_got = 0;
   int          cycle_count = 0;
   bit          quiet       = 1'b0;
   logic [31:0] key_pool [24];

   step_type directed_rows [0:22] = '{
      '{STEP_CAPACITY, lkvc_pkg::MODE_READ,  32'h0, 32'd2, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h0, 32'h0, 1'b1, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, KMIN,  KMAX,  1'b1, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  KMIN,  ONES,  1'b1, '{1'b1, KMAX, 1'b0, 32'h0}},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, KMAX,  KMIN,  1'b1, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, ONES,  32'h0, 1'b1, '{1'b0, 32'h0, 1'b1, KMIN}},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  KMIN,  32'h0, 1'b1, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, KMAX,  32'd5, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, 32'h0, ONES,  1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h0, 32'h0, 1'b0, MISS},
      '{STEP_CAPACITY, lkvc_pkg::MODE_READ,  32'h0, 32'd0, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  KMAX,  32'h0, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, 32'h1, 32'h1, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h0, 32'h0, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h1, 32'h0, 1'b0, MISS},
      '{STEP_CAPACITY, lkvc_pkg::MODE_READ,  32'h0, 32'd31, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, 32'h8000_0001, 32'haaaa_aaaa, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, 32'h1, 32'h5555_5555, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h1, 32'h0, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h8000_0001, 32'h0, 1'b0, MISS},
      '{STEP_CAPACITY, lkvc_pkg::MODE_READ,  32'h0, 32'd17, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_WRITE, 32'h2, 32'h1234_5678, 1'b0, MISS},
      '{STEP_ACCESS,   lkvc_pkg::MODE_READ,  32'h2, 32'h0, 1'b0, MISS}
   };

   int phase_caps [13] = '{16, 1, 0, 31, 17, 5, 8, 3, 12, 16, 2, 24, 6};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int usable_slots();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > lkvc_pkg::ENTRIES) return lkvc_pkg::ENTRIES;
      return int'(capacity_reg);
   endfunction

   // make slot s the most recent; entries more recent than it (every used entry if s was unused) age by one
   function automatic void promote(int s, bit was_used);
      logic [lkvc_pkg::RANK_W-1:0] old;
      old = slot_age[s];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (i != s && slot_used[i] && (!was_used || slot_age[i] < old)) slot_age[i]++;
      end
      slot_age[s] = '0;
   endfunction

   function automatic reply_type lru_access(logic mode, logic [lkvc_pkg::KEY_W-1:0] key,
                                            logic [lkvc_pkg::VAL_W-1:0] value);
      reply_type                   r;
      int                          s;
      bit                          found;
      bit                          any;
      logic [lkvc_pkg::RANK_W-1:0] oldest;
      r      = '0;
      s      = 0;
      found  = 1'b0;
      any    = 1'b0;
      oldest = '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (!found && slot_used[i] && slot_key[i] == key) begin
            s     = i;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         if (mode == lkvc_pkg::MODE_READ) r.read_value = slot_value[s];
         else slot_value[s] = value;
         promote(s, 1'b1);
      end else if (mode == lkvc_pkg::MODE_WRITE) begin
         if (slots_filled >= usable_slots()) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
               if (slot_used[i] && (!any || slot_age[i] > oldest)) begin
                  oldest = slot_age[i];
                  s      = i;
                  any    = 1'b1;
               end
            end
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[s];
            slot_key[s]   = key;
            slot_value[s] = value;
            promote(s, 1'b1);
         end else begin
            found = 1'b0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
               if (!found && !slot_used[i]) begin
                  s     = i;
                  found = 1'b1;
               end
            end
            promote(s, 1'b0);
            slot_key[s]   = key;
            slot_value[s] = value;
            slot_used[s]  = 1'b1;
            slots_filled++;
         end
      end
      return r;
   endfunction

   task automatic issue_access(logic mode, logic [lkvc_pkg::KEY_W-1:0] key,
                               logic [lkvc_pkg::VAL_W-1:0] value,
                               bit given, reply_type want);
      int        gap;
      reply_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
      predicted = lru_access(mode, key, value);
      replies_due.push_back(given ? want : predicted);
   endtask

   task automatic set_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg  = cap;
   endtask

   initial begin
      int          stall;
      bit          held;
      reply_type   got;
      reply_type   want;
      stall = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[0], rsp_tdata[31:0], rsp_tuser[1], rsp_tdata[63:32]};
            replies_got++;
            if (replies_due.size() == 0) begin
               $error("unexpected reply beat: %h", got);
               failures++;
            end else begin
               want = replies_due.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  failures++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                  failures++;
               end
               if (got.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                  failures++;
               end
               if (got.evicted_key !== want.evicted_key) begin
                  $error("evicted_key: expected %h, got %h", want.evicted_key,
                         got.evicted_key);
                  failures++;
               end
            end
         end
         if (!held && replies_got == HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int          n;
      logic [31:0] k;
      logic [31:0] v;
      int          r;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_used[i]  = 1'b0;
         slot_age[i]   = '0;
      end
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == STEP_CAPACITY) begin
            set_capacity(directed_rows[i].value[lkvc_pkg::CAP_W-1:0]);
         end else begin
            issue_access(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].value,
                         directed_rows[i].given, directed_rows[i].want);
         end
      end

      foreach (phase_caps[p]) begin
         set_capacity(lkvc_pkg::CAP_W'(phase_caps[p]));
         quiet = (p % 4 == 3);
         for (int i = 0; i < 24; i++) begin
            if ($urandom_range(0, 1) == 1) key_pool[i] = $urandom;
         end
         n = usable_slots() + 3;
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            r = $urandom_range(0, 19);
            k = (r < 18) ? key_pool[$urandom_range(0, n - 1)] : (r == 18) ? $urandom : KMIN;
            r = $urandom_range(0, 15);
            v = (r == 0) ? ONES : (r == 1) ? KMIN : (r == 2) ? 32'h0 : $urandom;
            issue_access($urandom_range(0, 1) ? lkvc_pkg::MODE_WRITE : lkvc_pkg::MODE_READ,
                         k, v, 1'b0, MISS);
         end
      end

      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4 * (lkvc_pkg::ENTRIES + 4)) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[lru_key_value_cache.f]
sv/lkvc_pkg.sv
sv/lkvc_kv_mem.sv
sv/lkvc_scan_unit.sv
sv/lru_key_value_cache.sv
sim/lru_key_value_cache_test.sv
